### rtl/fft_bin_power_averager_unit_defines.svh
// Assertion macros shared by the RTL.
`ifndef FFT_BIN_POWER_AVERAGER_UNIT_DEFINES_SVH
`define FFT_BIN_POWER_AVERAGER_UNIT_DEFINES_SVH

// Assert that an implication holds on every clock edge outside reset.
`define FBPA_ASSERT_IMP(label, clk_s, rst_n_s, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (cond)) else $error(msg);

// Assert that a condition never holds on any clock edge outside reset.
`define FBPA_ASSERT_NEVER(label, clk_s, rst_n_s, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);

`endif

### rtl/fbpa_pkg.sv
package fbpa_pkg;
	localparam int BINS_DEF = 4096;
	localparam int IDX_W = 12;
	localparam int SUM_W = 56;
	localparam int MEAN_W = 48;
	localparam int DB_W = 16;
	localparam logic [17:0] DB_SLOPE_Q16 = 18'd197283;
	localparam int DB_OFFSET_Q8 = 52404;

	typedef enum logic [1:0] {
		REG_AVG = 2'd0,
		REG_MODE = 2'd1,
		REG_AXIS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_POWER = 2'd0,
		MODE_RMS = 2'd1,
		MODE_DB = 2'd2,
		MODE_ZERO = 2'd3
	} out_mode_t;

	// per-item control that travels with the value through the finishing pipe
	typedef struct packed {
		logic [IDX_W-1:0] pos;
		logic [1:0] mode;
		logic last;
	} item_ctl_t;
endpackage

### rtl/fbpa_finish.sv
// Mean to output conversion: divide, then sqrt and log2; the mode picks the output.
// Fully pipelined, one item per cycle while en is high; all stages hold while en is low.
module fbpa_finish (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [fbpa_pkg::SUM_W-1:0] sum,
	input logic [7:0] div,
	input fbpa_pkg::item_ctl_t ctl_in,
	output logic out_valid,
	output logic [fbpa_pkg::MEAN_W-1:0] value,
	output logic signed [fbpa_pkg::DB_W-1:0] db,
	output fbpa_pkg::item_ctl_t ctl_out
);
	import fbpa_pkg::*;

	// stage counts: division 56 bit-steps in groups of 4, sqrt 24 steps in groups of 4,
	// log: normalize then 16 squarings one per stage
	localparam int DSTEP = 4;
	localparam int DST = SUM_W / DSTEP;          // 14
	localparam int SST = 24 / DSTEP;             // 6
	localparam int LST = 16;

	// ---------------- division by an 8-bit divisor, restoring ----------------
	logic [SUM_W-1:0] dq [0:DST];
	logic [8:0] dr [0:DST];
	logic [7:0] dd [0:DST];
	logic dv [0:DST];
	item_ctl_t dc [0:DST];

	always_comb begin
		dq[0] = sum;
		dr[0] = '0;
		dd[0] = (div == 8'd0) ? 8'd1 : div;
		dv[0] = in_valid;
		dc[0] = ctl_in;
	end

	for (genvar g = 0; g < DST; g++) begin : g_div
		logic [SUM_W-1:0] q_n;
		logic [8:0] r_n;
		always_comb begin
			logic [9:0] t;
			q_n = dq[g];
			r_n = dr[g];
			for (int k = 0; k < DSTEP; k++) begin
				t = {r_n, q_n[SUM_W-1]};
				q_n = {q_n[SUM_W-2:0], 1'b0};
				if (t >= {2'b00, dd[g]}) begin
					r_n = 9'(t - {2'b00, dd[g]});
					q_n[0] = 1'b1;
				end else begin
					r_n = t[8:0];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[g+1] <= 1'b0;
			end else if (en) begin
				dv[g+1] <= dv[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dq[g+1] <= q_n;
				dr[g+1] <= r_n;
				dd[g+1] <= dd[g];
				dc[g+1] <= dc[g];
			end
		end
	end

	// saturate mean
	logic [MEAN_W-1:0] mean_c;
	assign mean_c = (|dq[DST][SUM_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : dq[DST][MEAN_W-1:0];

	// ---------------- sqrt, one result bit per step ----------------
	logic [MEAN_W-1:0] sv [0:SST];
	logic [MEAN_W-1:0] sx [0:SST];
	logic [23:0] sr [0:SST];
	logic [MEAN_W-1:0] sm [0:SST];
	logic svv [0:SST];
	item_ctl_t sc [0:SST];

	always_comb begin
		sv[0] = mean_c;
		sx[0] = '0;
		sr[0] = '0;
		sm[0] = mean_c;
		svv[0] = dv[DST];
		sc[0] = dc[DST];
	end

	for (genvar g = 0; g < SST; g++) begin : g_sqrt
		logic [MEAN_W-1:0] v_n;
		logic [MEAN_W-1:0] x_n;
		logic [23:0] r_n;
		always_comb begin
			logic [MEAN_W+1:0] rem;
			logic [MEAN_W+1:0] trial;
			v_n = sv[g];
			x_n = sx[g];
			r_n = sr[g];
			for (int k = 0; k < DSTEP; k++) begin
				rem = {x_n, v_n[MEAN_W-1:MEAN_W-2]};
				trial = {(MEAN_W-24)'(0), r_n, 2'b01};
				v_n = {v_n[MEAN_W-3:0], 2'b00};
				if (rem >= trial) begin
					x_n = MEAN_W'(rem - trial);
					r_n = {r_n[22:0], 1'b1};
				end else begin
					x_n = rem[MEAN_W-1:0];
					r_n = {r_n[22:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				svv[g+1] <= 1'b0;
			end else if (en) begin
				svv[g+1] <= svv[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sv[g+1] <= v_n;
				sx[g+1] <= x_n;
				sr[g+1] <= r_n;
				sm[g+1] <= sm[g];
				sc[g+1] <= sc[g];
			end
		end
	end

	// ---------------- log2: exponent and Q30 mantissa ----------------
	logic [5:0] exp_c;
	logic [31:0] man_c;
	always_comb begin
		exp_c = '0;
		for (int b = 0; b < MEAN_W; b++) begin
			if (sm[SST][b]) exp_c = 6'(b);
		end
		if (exp_c > 6'd30) man_c = 32'(sm[SST] >> (exp_c - 6'd30));
		else man_c = 32'(sm[SST] << (6'd30 - exp_c));
	end

	logic [31:0] lm [0:LST];
	logic [15:0] lf [0:LST];
	logic [5:0] le [0:LST];
	logic lz [0:LST];
	logic [23:0] lr [0:LST];
	logic lvv [0:LST];
	item_ctl_t lc [0:LST];
	logic [MEAN_W-1:0] lm_mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvv[0] <= 1'b0;
		end else if (en) begin
			lvv[0] <= svv[SST];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lm[0] <= man_c;
			lf[0] <= '0;
			le[0] <= exp_c;
			lz[0] <= (sm[SST] == '0);
			lr[0] <= sr[SST];
			lc[0] <= sc[SST];
			lm_mean_q <= sm[SST];
		end
	end
	logic [MEAN_W-1:0] lmean [0:LST];
	assign lmean[0] = lm_mean_q;

	for (genvar g = 0; g < LST; g++) begin : g_log
		logic [31:0] m_n;
		logic bit_n;
		always_comb begin
			logic [63:0] p;
			p = 64'(lm[g]) * 64'(lm[g]);
			m_n = 32'(p >> 30);
			bit_n = m_n[31];
			if (bit_n) m_n = m_n >> 1;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lvv[g+1] <= 1'b0;
			end else if (en) begin
				lvv[g+1] <= lvv[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lm[g+1] <= m_n;
				lf[g+1] <= {lf[g][14:0], bit_n};
				le[g+1] <= le[g];
				lz[g+1] <= lz[g];
				lr[g+1] <= lr[g];
				lc[g+1] <= lc[g];
				lmean[g+1] <= lmean[g];
			end
		end
	end

	// ---------------- dB scale, one multiply stage then output ----------------
	logic [39:0] prod_s1;
	logic z_s1;
	logic v_s1;
	logic [23:0] r_s1;
	logic [MEAN_W-1:0] mean_s1;
	item_ctl_t c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= lvv[LST];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 40'({le[LST], lf[LST]}) * 40'(DB_SLOPE_Q16);
			z_s1 <= lz[LST];
			r_s1 <= lr[LST];
			mean_s1 <= lmean[LST];
			c_s1 <= lc[LST];
		end
	end

	logic signed [DB_W-1:0] db_c;
	logic [MEAN_W-1:0] val_c;
	always_comb begin
		logic signed [18:0] q;
		q = 19'(signed'({3'b000, 16'((prod_s1 + 40'(1 << 23)) >> 24)})) - 19'(DB_OFFSET_Q8);
		if (z_s1) db_c = -16'sd32768;
		else if (q > 19'sd32767) db_c = 16'sd32767;
		else if (q < -19'sd32768) db_c = -16'sd32768;
		else db_c = q[15:0];
		val_c = '0;
		case (c_s1.mode)
			MODE_POWER: val_c = mean_s1;
			MODE_RMS: val_c = MEAN_W'(r_s1);
			default: val_c = '0;
		endcase
		if (c_s1.mode != MODE_DB) db_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			value <= val_c;
			db <= db_c;
			ctl_out <= c_s1;
		end
	end
endmodule

### rtl/fft_bin_power_averager_unit.sv
// Channel   Dir  Fields (tdata low bit up)                 Ctrl
// s_axis    in   bin_index[11:0] real[35:12] imag[59:36]    tvalid/tready
// m_axis    out  out_index[11:0] out_value[59:12]           tvalid/tready
//                out_db[75:60], pad to 80                   tuser = spectrum_done
// cfg       in   we, idx[1:0], wdata[7:0]
// One bin per cycle sustained unless stalled or clearing. Read-modify-write
// of the sum memory spans stage 1 (read) and stage 2 (add, write); a repeat of
// the same bin in the next cycle is forwarded. A result passes two sum stages, then
// 39 finishing stages (divide, sqrt, log); all stages advance together and stall
// while the output register is full and not taken.
// Reset: a clearing pass zeroes every sum memory entry (BINS, 4096 by default);
// the input is not ready until it ends.
module fft_bin_power_averager_unit #(
	parameter int BINS = fbpa_pkg::BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // bin_index, bin_real, bin_imag
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [79:0] m_axis_tdata, // out_index, out_value, out_db
	output logic m_axis_tuser, // spectrum_done
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [7:0] cfg_wdata
);
	import fbpa_pkg::*;
	`include "fft_bin_power_averager_unit_defines.svh"

	localparam int AW = $clog2(BINS);

	logic [7:0] avg_q;
	logic [1:0] mode_q;
	logic [1:0] axis_q;
	logic [7:0] fcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= 8'd1;
			mode_q <= MODE_POWER;
			axis_q <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_AVG: avg_q <= cfg_wdata;
				REG_MODE: mode_q <= cfg_wdata[1:0];
				REG_AXIS: axis_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// sum memory clearing after reset
	logic clr_q;
	logic [AW-1:0] clr_addr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(BINS - 1)) clr_q <= 1'b0;
		end
	end

	// whole pipe advances unless the output holds an untaken item
	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && !clr_q;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [AW-1:0] idx_c;
	logic [23:0] re_c, im_c;
	assign idx_c = s_axis_tdata[AW-1:0];
	always_comb begin
		re_c = s_axis_tdata[35] ? 24'(-s_axis_tdata[35:12]) : s_axis_tdata[35:12];
		im_c = s_axis_tdata[59] ? 24'(-s_axis_tdata[59:36]) : s_axis_tdata[59:36];
	end
	// 0x800000 negates to itself: magnitude 2^23 fits unsigned 24 bits

	logic [7:0] n_c;
	assign n_c = (avg_q == 8'd0) ? 8'd1 : avg_q;
	logic first_c, final_c, last_c;
	assign first_c = (fcnt_q == 8'd0);
	assign final_c = (9'(fcnt_q) + 9'd1 >= 9'(n_c));
	assign last_c = (idx_c == AW'(BINS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (acc && last_c) begin
			fcnt_q <= final_c ? 8'd0 : fcnt_q + 8'd1;
		end
	end

	// stage 1: squares, memory read issued
	logic v_s1, first_s1, final_s1, last_s1;
	logic [AW-1:0] idx_s1;
	logic [47:0] rr_s1, ii_s1;
	logic [7:0] n_s1;
	logic [1:0] mode_s1;
	logic [AW-1:0] pos_s1;
	logic [SUM_W-1:0] mem [0:BINS-1];
	logic [SUM_W-1:0] rd_s1;

	logic [AW-1:0] pos_c;
	always_comb begin
		pos_c = idx_c;
		if (axis_q[1]) pos_c = {~idx_c[AW-1], idx_c[AW-2:0]};
		if (axis_q[0]) pos_c = ~pos_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_c;
			rr_s1 <= re_c * re_c;
			ii_s1 <= im_c * im_c;
			first_s1 <= first_c;
			final_s1 <= final_c;
			last_s1 <= last_c;
			n_s1 <= n_c;
			mode_s1 <= mode_q;
			pos_s1 <= pos_c;
			rd_s1 <= mem[idx_c];
		end
	end

	// stage 2: add and write back; forward previous write on same bin
	logic v_s2;
	logic [AW-1:0] idx_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [SUM_W-1:0] old_c, sum_c;
	always_comb begin
		logic [SUM_W:0] t;
		old_c = (v_s2 && idx_s2 == idx_s1) ? sum_s2 : rd_s1;
		t = (SUM_W+1)'(rr_s1) + (SUM_W+1)'(ii_s1);
		if (!first_s1) t = t + (SUM_W+1)'(old_c);
		sum_c = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
	end

	item_ctl_t ctl_s2;
	logic fv_s2;
	logic [7:0] n_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			fv_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			fv_s2 <= v_s1 && final_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= idx_s1;
			sum_s2 <= sum_c;
			n_s2 <= n_s1;
			ctl_s2 <= '{pos: pos_s1, mode: mode_s1, last: last_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (en && v_s1) begin
			mem[idx_s1] <= sum_c;
		end
	end

	logic fo_v;
	logic [MEAN_W-1:0] fo_val;
	logic signed [DB_W-1:0] fo_db;
	item_ctl_t fo_ctl;

	fbpa_finish u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fv_s2),
		.sum(sum_s2),
		.div(n_s2),
		.ctl_in(ctl_s2),
		.out_valid(fo_v),
		.value(fo_val),
		.db(fo_db),
		.ctl_out(fo_ctl)
	);

	assign m_axis_tvalid = fo_v;
	assign m_axis_tdata = {4'd0, fo_db, fo_val, 12'(fo_ctl.pos)};
	assign m_axis_tuser = fo_ctl.last;

	`FBPA_ASSERT_IMP(a_out_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "output changed while stalled")
	`FBPA_ASSERT_IMP(a_ready, clk, arst_n, (s_axis_tready == (!clr_q && (!m_axis_tvalid || m_axis_tready))), "ready mismatch")
	`FBPA_ASSERT_IMP(a_fcnt, clk, arst_n, (fcnt_q < 8'd255 || avg_q == 8'd0 || fcnt_q < avg_q), "frame count")
endmodule
